>>> sv/stpseq_pkg.sv
// Shared constants, command codes and types for the full-step sequencer.
package stpseq_pkg;

    // Command codes carried in the input tuser
    localparam logic [1:0] FN_TICK    = 2'd0;
    localparam logic [1:0] FN_COUNTED = 2'd1;
    localparam logic [1:0] FN_CONT    = 2'd2;

    // Timer width and microseconds per minute (fits in the timer width)
    localparam int PERIOD_W = 26;
    localparam logic [PERIOD_W-1:0] US_PER_MIN = 26'd60000000;

    // Iteration counts for the serial multiply and divide
    localparam int MUL_STEPS = 16;
    localparam int DIV_STEPS = PERIOD_W;

    // Coil drive per phase: bit0 A1, bit1 A2, bit2 B1, bit3 B2
    localparam logic [3:0] PINS_PH0 = 4'b0101;
    localparam logic [3:0] PINS_PH1 = 4'b1001;
    localparam logic [3:0] PINS_PH2 = 4'b1010;
    localparam logic [3:0] PINS_PH3 = 4'b0110;

    // Result word, first field in the highest bits
    typedef struct packed {
        logic       rejected;
        logic       stepped;
        logic       running;
        logic [3:0] coil_pins;
    } t_out_word;

    // Two-phase full-step pattern lookup
    function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
        logic [3:0] pins;
        case (ph)
            2'd0:    pins = PINS_PH0;
            2'd1:    pins = PINS_PH1;
            2'd2:    pins = PINS_PH2;
            default: pins = PINS_PH3;
        endcase
        return pins;
    endfunction

endpackage

>>> sv/stepper_full_step_sequencer_unit.sv
// Full-step sequencer for one bipolar stepper channel with serial period divider.
//
//  channel  | direction | signals                                  | content
//  ---------+-----------+------------------------------------------+---------------------------
//  s_axis   | in        | s_axis_tvalid/tready/tdata/tuser         | command word
//  m_axis   | out       | m_axis_tvalid/tready/tdata               | pin and status word
//  apb      | in/out    | psel/penable/pwrite/paddr/pwdata/prdata  | steps_per_rev at 0x0
//
// A tick or a rejected start is answered in the cycle after acceptance.
// A valid start runs the bit-serial steps_per_rev * rpm product, then the
// restoring divide of 60000000 by it, then a commit that waits for m_axis.
// Reset (synchronous, active low) sets steps_per_rev to 200, stops the timer.
// The result register holds one word; while it is full and m_axis stalls, no
// command is taken and a finished start waits until the pending word is taken.
module stepper_full_step_sequencer_unit
    import stpseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // [15:0] speed_rpm, [47:16] step_count, [48] reverse
    input  logic [1:0]  s_axis_tuser,  // [1:0] func
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [3:0] coil_pins, [4] running, [5] stepped, [6] rejected
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // control and motor state
    logic [1:0]          r_state,    n_state;
    logic [15:0]         r_spr;
    logic [1:0]          r_phase,    n_phase;
    logic [31:0]         r_steps,    n_steps;
    logic                r_cont,     n_cont;
    logic                r_rev,      n_rev;
    logic                r_running,  n_running;
    logic [PERIOD_W-1:0] r_tick,     n_tick;
    logic [PERIOD_W-1:0] r_period,   n_period;
    logic [3:0]          r_pins,     n_pins;
    logic                r_out_vld,  n_out_vld;

    // datapath (payload, no reset)
    t_out_word           r_out,      n_out;
    logic [4:0]          r_cnt,      n_cnt;
    logic [31:0]         r_mcand,    n_mcand;
    logic [15:0]         r_mplier,   n_mplier;
    logic [31:0]         r_prod,     n_prod;
    logic [31:0]         r_rem,      n_rem;
    logic [PERIOD_W-1:0] r_quo,      n_quo;
    logic                r_cmd_cnt,  n_cmd_cnt;
    logic [31:0]         r_cmd_steps, n_cmd_steps;
    logic                r_cmd_rev,  n_cmd_rev;

    logic                w_accept;
    logic                w_out_free;
    logic [15:0]         w_rpm;
    logic [31:0]         w_prod_sum;
    logic [32:0]         w_shifted;
    logic [32:0]         w_sub;
    logic                w_ge;
    logic [PERIOD_W-1:0] w_tick_inc;

    // handshakes
    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out};
    assign w_rpm         = s_axis_tdata[15:0];

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_spr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr <= 16'd200;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_spr <= pwdata[15:0];
        end
    end

    // serial arithmetic terms
    assign w_prod_sum = r_prod + (r_mplier[0] ? r_mcand : 32'd0);
    assign w_shifted  = {r_rem, US_PER_MIN[r_cnt]};
    assign w_sub      = w_shifted - {1'b0, r_prod};
    assign w_ge       = (w_shifted >= {1'b0, r_prod});
    assign w_tick_inc = r_tick + 1'b1;

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_steps     = r_steps;
        n_cont      = r_cont;
        n_rev       = r_rev;
        n_running   = r_running;
        n_tick      = r_tick;
        n_period    = r_period;
        n_pins      = r_pins;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out       = r_out;
        n_cnt       = r_cnt;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cmd_cnt   = r_cmd_cnt;
        n_cmd_steps = r_cmd_steps;
        n_cmd_rev   = r_cmd_rev;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out.stepped  = 1'b0;
                    n_out.rejected = 1'b0;
                    case (s_axis_tuser)
                        FN_TICK: begin
                            if (r_running) begin
                                if (w_tick_inc >= r_period) begin
                                    // step event: drive pins, then move phase
                                    n_tick        = '0;
                                    n_out.stepped = 1'b1;
                                    n_pins        = coil_pattern(r_phase);
                                    if (!r_cont) begin
                                        if (r_steps == 32'd0) begin
                                            n_running = 1'b0;
                                        end else if (!r_steps[31]) begin
                                            n_steps = r_steps - 32'd1;
                                            n_phase = r_phase + 2'd1;
                                        end else begin
                                            n_steps = r_steps + 32'd1;
                                            n_phase = r_phase - 2'd1;
                                        end
                                    end else if (!r_rev) begin
                                        n_phase = r_phase + 2'd1;
                                    end else begin
                                        n_phase = r_phase - 2'd1;
                                    end
                                end else begin
                                    n_tick = w_tick_inc;
                                end
                            end
                            n_out_vld = 1'b1;
                        end
                        FN_COUNTED, FN_CONT: begin
                            if (w_rpm == 16'd0) begin
                                n_out.rejected = 1'b1;
                                n_out_vld      = 1'b1;
                            end else begin
                                n_cmd_cnt   = (s_axis_tuser == FN_COUNTED);
                                n_cmd_steps = s_axis_tdata[47:16];
                                n_cmd_rev   = s_axis_tdata[48];
                                n_mcand     = {16'd0, r_spr};
                                n_mplier    = w_rpm;
                                n_prod      = 32'd0;
                                n_cnt       = 5'd0;
                                n_state     = ST_MUL;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                    n_out.coil_pins = n_pins;
                    n_out.running   = n_running;
                end
            end
            ST_MUL: begin
                // one multiplier bit per cycle
                n_mcand  = {r_mcand[30:0], 1'b0};
                n_mplier = {1'b0, r_mplier[15:1]};
                n_prod   = w_prod_sum;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(MUL_STEPS - 1)) begin
                    // zero divisor only from zero steps_per_rev: divide by one
                    n_prod  = (w_prod_sum == 32'd0) ? 32'd1 : w_prod_sum;
                    n_rem   = 32'd0;
                    n_quo   = '0;
                    n_cnt   = 5'(DIV_STEPS - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle, dividend bits MSB first
                n_rem = w_ge ? w_sub[31:0] : w_shifted[31:0];
                n_quo = {r_quo[PERIOD_W-2:0], w_ge};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_period  = (r_quo == '0) ? PERIOD_W'(1) : r_quo;
                    n_tick    = '0;
                    n_running = 1'b1;
                    if (r_cmd_cnt) begin
                        n_steps = r_cmd_steps;
                        n_cont  = 1'b0;
                    end else begin
                        n_rev  = r_cmd_rev;
                        n_cont = 1'b1;
                    end
                    n_out.coil_pins = r_pins;
                    n_out.running   = 1'b1;
                    n_out.stepped   = 1'b0;
                    n_out.rejected  = 1'b0;
                    n_out_vld       = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= 2'd0;
            r_steps   <= 32'd0;
            r_cont    <= 1'b0;
            r_rev     <= 1'b0;
            r_running <= 1'b0;
            r_tick    <= '0;
            r_period  <= PERIOD_W'(1);
            r_pins    <= 4'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_steps   <= n_steps;
            r_cont    <= n_cont;
            r_rev     <= n_rev;
            r_running <= n_running;
            r_tick    <= n_tick;
            r_period  <= n_period;
            r_pins    <= n_pins;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_cnt       <= n_cnt;
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_prod      <= n_prod;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cmd_cnt   <= n_cmd_cnt;
        r_cmd_steps <= n_cmd_steps;
        r_cmd_rev   <= n_cmd_rev;
    end

`ifndef SYNTHESIS
    // input is only taken while no start is being computed
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == ST_IDLE))
        else $error("command word taken while divider busy");

    // restoring divide keeps the partial remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_prod))
        else $error("partial remainder not below divisor");

    // step period never reaches zero
    a_period_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period != '0)
        else $error("zero step period");

    // timer only stops on a step event word
    a_stop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_running) |-> (r_out_vld && r_out.stepped && !r_out.running))
        else $error("timer stopped without a step event");
`endif

endmodule
